### hdl/crt_pkg.sv
// Shared types and constants of the zoned Chebyshev resistance-to-temperature converter.
// No dependencies; the files that use it refer to it by scoped names.
package crt_pkg;

  typedef enum logic [2:0] {
    KIND_CONVERT = 3'd0,
    KIND_COEF    = 3'd1,
    KIND_R_LOW   = 3'd2,
    KIND_R_HIGH  = 3'd3,
    KIND_LOG_LOW = 3'd4,
    KIND_LOG_HIGH= 3'd5,
    KIND_COUNT   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_NO_ZONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1,
    CFG_ZONES      = 2'd2
  } cfg_idx_e;

  // word offsets of one zone record in the zone memory
  localparam logic [2:0] FLD_R_LOW    = 3'd0;
  localparam logic [2:0] FLD_R_HIGH   = 3'd1;
  localparam logic [2:0] FLD_LOG_LOW  = 3'd2;
  localparam logic [2:0] FLD_LOG_HIGH = 3'd3;
  localparam logic [2:0] FLD_COUNT    = 3'd4;
  localparam int         ZONE_STRIDE  = 8;

  localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
  localparam logic [28:0]        LOG10_2_Q30 = 29'd323228497;

  typedef enum logic [4:0] {
    S_IDLE, S_ZRLO, S_ZRHI, S_ZCHK, S_RLL, S_RLH, S_RCNT, S_RCAP,
    S_NORM, S_SQ, S_LMH, S_LML, S_LRND, S_DIVSET, S_DIV,
    S_CREAD, S_TUPD, S_AMUL, S_ACC, S_DONE
  } crt_state_e;

  typedef struct packed {
    logic signed [31:0] temperature;
    status_e            status;
  } crt_result_t;

endpackage

### hdl/crt_ifs.sv
// Valid/ready channel interfaces for the converter's input and result beats.
// No dependencies.
interface crt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  zone_sel;
  logic [3:0]  coef_slot;
  logic signed [31:0] table_word;
  logic [31:0] resistance;
  modport source (output valid, kind, zone_sel, coef_slot, table_word, resistance,
                  input ready);
  modport sink   (input valid, kind, zone_sel, coef_slot, table_word, resistance,
                  output ready);
endinterface

interface crt_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] temperature;
  logic [1:0]  status;
  modport source (output valid, temperature, status, input ready);
  modport sink   (input valid, temperature, status, output ready);
endinterface

### hdl/chebyshev_resistance_to_temperature.sv
// Loads are written when accepted; a convert beat passes zone search, normalize, squaring,
// divide and a multiply-accumulate per coefficient before it reaches the output register,
// while a range or zero-zone miss goes straight to it.
// One convert at a time; the next beat is taken in the cycle after the result leaves
// the core, which holds while the output register is full. Reset clears control and loads
// the configuration reset values; table memories hold nothing defined until written.
module chebyshev_resistance_to_temperature #(
  parameter int MAX_ZONES = 4,
  parameter int MAX_COEFS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crt_in_if.sink     in_i,
  crt_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  localparam int ZAW = $clog2(MAX_ZONES * crt_pkg::ZONE_STRIDE);
  localparam int CAW = $clog2(MAX_ZONES * MAX_COEFS);

  logic [31:0] range_low_q, range_high_q;
  logic [2:0]  zones_q;

  logic        accept, start;
  logic        core_idle;
  logic        zone_we, coef_we;
  logic [ZAW-1:0] zone_waddr, zone_raddr;
  logic [CAW-1:0] coef_waddr, coef_raddr;
  logic [31:0] zone_wdata, zone_rdata, coef_rdata;
  logic        zone_re, coef_re;
  logic [2:0]  zfld;
  logic        res_valid, res_take;
  crt_pkg::crt_result_t result;
  logic        ov_q;
  crt_pkg::crt_result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '1;
      zones_q      <= 3'd1;
    end else if (cfg_we_i) begin
      case (crt_pkg::cfg_idx_e'(cfg_idx_i))
        crt_pkg::CFG_RANGE_LOW:  range_low_q  <= cfg_wdata_i;
        crt_pkg::CFG_RANGE_HIGH: range_high_q <= cfg_wdata_i;
        crt_pkg::CFG_ZONES:      zones_q      <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = core_idle;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    start      = 1'b0;
    zone_we    = 1'b0;
    coef_we    = 1'b0;
    zfld       = crt_pkg::FLD_R_LOW;
    zone_wdata = in_i.table_word;
    case (crt_pkg::kind_e'(in_i.kind))
      crt_pkg::KIND_CONVERT: start = accept;
      crt_pkg::KIND_COEF: begin
        coef_we = accept && (32'(in_i.zone_sel) < MAX_ZONES)
                         && (32'(in_i.coef_slot) < MAX_COEFS);
      end
      crt_pkg::KIND_R_LOW, crt_pkg::KIND_R_HIGH, crt_pkg::KIND_LOG_LOW,
      crt_pkg::KIND_LOG_HIGH, crt_pkg::KIND_COUNT: begin
        zone_we = accept && (32'(in_i.zone_sel) < MAX_ZONES);
        zfld    = in_i.kind - 3'd2;
        if (crt_pkg::kind_e'(in_i.kind) == crt_pkg::KIND_COUNT) begin
          if (in_i.table_word < 0) begin
            zone_wdata = '0;
          end else if (in_i.table_word > MAX_COEFS) begin
            zone_wdata = 32'(MAX_COEFS);
          end
        end
      end
      default: ;
    endcase
  end

  assign zone_waddr = ZAW'(in_i.zone_sel * crt_pkg::ZONE_STRIDE + zfld);
  assign coef_waddr = CAW'(in_i.zone_sel * MAX_COEFS + in_i.coef_slot);

  crt_ram #(.WIDTH(32), .DEPTH(MAX_ZONES * crt_pkg::ZONE_STRIDE)) u_zone_ram (
    .clk_i   (clk_i),
    .we_i    (zone_we),
    .waddr_i (zone_waddr),
    .wdata_i (zone_wdata),
    .re_i    (zone_re),
    .raddr_i (zone_raddr),
    .rdata_o (zone_rdata)
  );

  crt_ram #(.WIDTH(32), .DEPTH(MAX_ZONES * MAX_COEFS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_i.table_word),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  crt_core #(.MAX_ZONES(MAX_ZONES), .MAX_COEFS(MAX_COEFS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .resistance_i (in_i.resistance),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .zones_i      (zones_q),
    .idle_o       (core_idle),
    .zone_re_o    (zone_re),
    .zone_raddr_o (zone_raddr),
    .zone_rdata_i (zone_rdata),
    .coef_re_o    (coef_re),
    .coef_raddr_o (coef_raddr),
    .coef_rdata_i (coef_rdata),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .result_o     (result)
  );

  assign res_take = !ov_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res_valid && res_take) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= result;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.temperature = out_q.temperature;
  assign out_o.status      = out_q.status;
endmodule

### hdl/crt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module crt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### hdl/crt_mul.sv
// Shared 33x33 signed multiplier with a registered product.
// No dependencies.
module crt_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);
  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;
endmodule

### hdl/crt_core.sv
// Conversion sequencer: zone search, log10, normalization divide, Chebyshev sum.
// Depends on crt_pkg and crt_mul; reads the zone and coefficient memories.
module crt_core #(
  parameter int MAX_ZONES = 4,
  parameter int MAX_COEFS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [31:0]                                   resistance_i,
  input  logic [31:0]                                   range_low_i,
  input  logic [31:0]                                   range_high_i,
  input  logic [2:0]                                    zones_i,
  output logic                                          idle_o,
  output logic                                          zone_re_o,
  output logic [$clog2(MAX_ZONES*crt_pkg::ZONE_STRIDE)-1:0] zone_raddr_o,
  input  logic [31:0]                                   zone_rdata_i,
  output logic                                          coef_re_o,
  output logic [$clog2(MAX_ZONES*MAX_COEFS)-1:0]        coef_raddr_o,
  input  logic [31:0]                                   coef_rdata_i,
  output logic                                          res_valid_o,
  input  logic                                          res_take_i,
  output crt_pkg::crt_result_t                          result_o
);
  localparam int ZCW = $clog2(MAX_ZONES + 1);
  localparam int JCW = $clog2(MAX_COEFS + 1);
  localparam int ZAW = $clog2(MAX_ZONES * crt_pkg::ZONE_STRIDE);
  localparam int CAW = $clog2(MAX_ZONES * MAX_COEFS);

  crt_pkg::crt_state_e state_q, state_d;
  crt_pkg::status_e    status_q, status_d;

  logic [31:0]        r_q, r_d;
  logic [ZCW-1:0]     zone_q, zone_d;
  logic               lo_ok_q, lo_ok_d;
  logic signed [31:0] llo_q, llo_d, lhi_q, lhi_d;
  logic [JCW-1:0]     n_q, n_d, j_q, j_d;
  logic [31:0]        m_q, m_d;
  logic [4:0]         pos_q, pos_d, k_q, k_d;
  logic [29:0]        frac_q, frac_d;
  logic [34:0]        mag_q, mag_d;
  logic               lneg_q, lneg_d;
  logic [65:0]        lacc_q, lacc_d;
  logic signed [31:0] zv_q, zv_d;
  logic               xneg_q, xneg_d;
  logic [34:0]        rem_q, rem_d;
  logic [32:0]        ad_q, ad_d;
  logic [29:0]        quo_q, quo_d;
  logic signed [31:0] x_q, x_d, tprev_q, tprev_d, tcur_q, tcur_d;
  logic signed [39:0] sum_q, sum_d;

  logic               mul_en;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [ZCW-1:0]     nz;
  logic [2:0]         zfld;
  logic [32:0]        sq_hi;
  logic               sq_bit;
  logic [31:0]        sq_adj;
  logic [31:0]        sq_in;
  logic [29:0]        frac_full;
  logic signed [5:0]  expo;
  logic signed [35:0] l2;
  logic [65:0]        lsum;
  logic [31:0]        lmag;
  logic signed [34:0] num;
  logic signed [32:0] den;
  logic [34:0]        an;
  logic [32:0]        ad;
  logic [34:0]        rem2;
  logic               dbit;
  logic [29:0]        quo_full;
  logic signed [65:0] p_rnd29, p_rnd30;
  logic signed [33:0] tq, tn;
  logic signed [31:0] tclamp, tsel;
  logic signed [32:0] term;
  logic signed [31:0] sat_sum;
  crt_pkg::crt_state_e after_x;

  crt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign nz = (32'(zones_i) > MAX_ZONES) ? ZCW'(MAX_ZONES) : ZCW'(zones_i);

  // squaring step of the log2 fraction
  assign sq_hi     = prod[63:31];
  assign sq_bit    = sq_hi[32];
  assign sq_adj    = sq_bit ? sq_hi[32:1] : sq_hi[31:0];
  assign sq_in     = (k_q == 5'd0) ? m_q : sq_adj;
  assign frac_full = {frac_q[28:0], sq_bit};
  assign expo      = $signed({1'b0, pos_q} - 6'd16);
  assign l2        = {expo, frac_full};

  assign lsum = {lacc_q[49:0], 16'd0} + 66'(unsigned'(prod)) + 66'h8000_0000;
  assign lmag = lsum[63:32];

  assign num = {{2{zv_q[31]}}, zv_q, 1'b0} - {{3{llo_q[31]}}, llo_q}
             - {{3{lhi_q[31]}}, lhi_q};
  assign den = {lhi_q[31], lhi_q} - {llo_q[31], llo_q};
  assign an  = num[34] ? 35'(-num) : 35'(num);
  assign ad  = den[32] ? 33'(-den) : 33'(den);

  assign rem2     = {rem_q[33:0], 1'b0};
  assign dbit     = rem2 >= {2'b00, ad_q};
  assign quo_full = {quo_q[28:0], dbit};

  assign p_rnd29 = (prod[65] ? (prod + 66'sd536870911) : prod) >>> 29;
  assign p_rnd30 = (prod[65] ? (prod + 66'sd1073741823) : prod) >>> 30;
  assign tq      = p_rnd29[33:0];
  assign tn      = tq - {{2{tprev_q[31]}}, tprev_q};
  assign tclamp  = (tn > 34'sd1073741824) ? crt_pkg::Q30_ONE :
                   (tn < -34'sd1073741824) ? -crt_pkg::Q30_ONE : tn[31:0];
  assign tsel    = (j_q == '0) ? tprev_q : tcur_q;
  assign term    = p_rnd30[32:0];

  assign sat_sum = (sum_q > 40'sd2147483647) ? 32'sh7FFF_FFFF :
                   (sum_q < -40'sd2147483648) ? 32'sh8000_0000 : sum_q[31:0];

  assign after_x = (n_q == '0) ? crt_pkg::S_DONE : crt_pkg::S_CREAD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    r_q      <= r_d;
    zone_q   <= zone_d;
    lo_ok_q  <= lo_ok_d;
    llo_q    <= llo_d;
    lhi_q    <= lhi_d;
    n_q      <= n_d;
    j_q      <= j_d;
    m_q      <= m_d;
    pos_q    <= pos_d;
    k_q      <= k_d;
    frac_q   <= frac_d;
    mag_q    <= mag_d;
    lneg_q   <= lneg_d;
    lacc_q   <= lacc_d;
    zv_q     <= zv_d;
    xneg_q   <= xneg_d;
    rem_q    <= rem_d;
    ad_q     <= ad_d;
    quo_q    <= quo_d;
    x_q      <= x_d;
    tprev_q  <= tprev_d;
    tcur_q   <= tcur_d;
    sum_q    <= sum_d;
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    r_d      = r_q;
    zone_d   = zone_q;
    lo_ok_d  = lo_ok_q;
    llo_d    = llo_q;
    lhi_d    = lhi_q;
    n_d      = n_q;
    j_d      = j_q;
    m_d      = m_q;
    pos_d    = pos_q;
    k_d      = k_q;
    frac_d   = frac_q;
    mag_d    = mag_q;
    lneg_d   = lneg_q;
    lacc_d   = lacc_q;
    zv_d     = zv_q;
    xneg_d   = xneg_q;
    rem_d    = rem_q;
    ad_d     = ad_q;
    quo_d    = quo_q;
    x_d      = x_q;
    tprev_d  = tprev_q;
    tcur_d   = tcur_q;
    sum_d    = sum_q;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    zone_re_o = 1'b0;
    zfld     = crt_pkg::FLD_R_LOW;
    coef_re_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      crt_pkg::S_IDLE: begin
        if (start_i) begin
          r_d      = resistance_i;
          zone_d   = '0;
          sum_d    = '0;
          status_d = crt_pkg::STATUS_OK;
          if (resistance_i <= range_low_i || resistance_i >= range_high_i) begin
            status_d = crt_pkg::STATUS_RANGE;
            state_d  = crt_pkg::S_DONE;
          end else if (nz == '0) begin
            status_d = crt_pkg::STATUS_NO_ZONE;
            state_d  = crt_pkg::S_DONE;
          end else begin
            state_d = crt_pkg::S_ZRLO;
          end
        end
      end
      crt_pkg::S_ZRLO: begin
        zone_re_o = 1'b1;
        zfld      = crt_pkg::FLD_R_LOW;
        state_d   = crt_pkg::S_ZRHI;
      end
      crt_pkg::S_ZRHI: begin
        zone_re_o = 1'b1;
        zfld      = crt_pkg::FLD_R_HIGH;
        lo_ok_d   = r_q >= zone_rdata_i;
        state_d   = crt_pkg::S_ZCHK;
      end
      crt_pkg::S_ZCHK: begin
        if (lo_ok_q && r_q <= zone_rdata_i) begin
          state_d = crt_pkg::S_RLL;
        end else if (zone_q + 1'b1 == nz) begin
          status_d = crt_pkg::STATUS_NO_ZONE;
          state_d  = crt_pkg::S_DONE;
        end else begin
          zone_d  = zone_q + 1'b1;
          state_d = crt_pkg::S_ZRLO;
        end
      end
      crt_pkg::S_RLL: begin
        zone_re_o = 1'b1;
        zfld      = crt_pkg::FLD_LOG_LOW;
        state_d   = crt_pkg::S_RLH;
      end
      crt_pkg::S_RLH: begin
        zone_re_o = 1'b1;
        zfld      = crt_pkg::FLD_LOG_HIGH;
        llo_d     = zone_rdata_i;
        state_d   = crt_pkg::S_RCNT;
      end
      crt_pkg::S_RCNT: begin
        zone_re_o = 1'b1;
        zfld      = crt_pkg::FLD_COUNT;
        lhi_d     = zone_rdata_i;
        state_d   = crt_pkg::S_RCAP;
      end
      crt_pkg::S_RCAP: begin
        n_d     = zone_rdata_i[JCW-1:0];
        m_d     = r_q;
        pos_d   = 5'd31;
        state_d = crt_pkg::S_NORM;
      end
      crt_pkg::S_NORM: begin
        if (m_q == '0) begin
          zv_d    = '0;
          state_d = crt_pkg::S_DIVSET;
        end else if (m_q[31]) begin
          k_d     = '0;
          frac_d  = '0;
          state_d = crt_pkg::S_SQ;
        end else begin
          m_d   = {m_q[30:0], 1'b0};
          pos_d = pos_q - 5'd1;
        end
      end
      crt_pkg::S_SQ: begin
        if (k_q != 5'd30) begin
          mul_en = 1'b1;
          mul_a  = {1'b0, sq_in};
          mul_b  = {1'b0, sq_in};
        end
        if (k_q != 5'd0) begin
          frac_d = frac_full;
        end
        k_d = k_q + 5'd1;
        if (k_q == 5'd30) begin
          lneg_d  = l2[35];
          mag_d   = l2[35] ? 35'(-l2) : 35'(l2);
          state_d = crt_pkg::S_LMH;
        end
      end
      crt_pkg::S_LMH: begin
        mul_en  = 1'b1;
        mul_a   = {14'd0, mag_q[34:16]};
        mul_b   = {4'd0, crt_pkg::LOG10_2_Q30};
        state_d = crt_pkg::S_LML;
      end
      crt_pkg::S_LML: begin
        mul_en  = 1'b1;
        mul_a   = {17'd0, mag_q[15:0]};
        mul_b   = {4'd0, crt_pkg::LOG10_2_Q30};
        lacc_d  = unsigned'(prod);
        state_d = crt_pkg::S_LRND;
      end
      crt_pkg::S_LRND: begin
        zv_d    = lneg_q ? -$signed(lmag) : $signed(lmag);
        state_d = crt_pkg::S_DIVSET;
      end
      crt_pkg::S_DIVSET: begin
        xneg_d  = num[34] ^ den[32];
        tprev_d = crt_pkg::Q30_ONE;
        j_d     = '0;
        if (den == '0) begin
          x_d     = '0;
          tcur_d  = '0;
          state_d = after_x;
        end else if (an >= {2'b00, ad}) begin
          x_d     = (num[34] ^ den[32]) ? -crt_pkg::Q30_ONE : crt_pkg::Q30_ONE;
          tcur_d  = x_d;
          state_d = after_x;
        end else begin
          rem_d   = an;
          ad_d    = ad;
          quo_d   = '0;
          k_d     = '0;
          state_d = crt_pkg::S_DIV;
        end
      end
      crt_pkg::S_DIV: begin
        rem_d = dbit ? (rem2 - {2'b00, ad_q}) : rem2;
        quo_d = quo_full;
        k_d   = k_q + 5'd1;
        if (k_q == 5'd29) begin
          x_d     = xneg_q ? -$signed({2'b00, quo_full}) : $signed({2'b00, quo_full});
          tcur_d  = x_d;
          state_d = after_x;
        end
      end
      crt_pkg::S_CREAD: begin
        coef_re_o = 1'b1;
        if (j_q >= JCW'(2)) begin
          mul_en = 1'b1;
          mul_a  = {x_q[31], x_q};
          mul_b  = {tcur_q[31], tcur_q};
        end
        state_d = crt_pkg::S_TUPD;
      end
      crt_pkg::S_TUPD: begin
        if (j_q >= JCW'(2)) begin
          tprev_d = tcur_q;
          tcur_d  = tclamp;
        end
        state_d = crt_pkg::S_AMUL;
      end
      crt_pkg::S_AMUL: begin
        mul_en  = 1'b1;
        mul_a   = {coef_rdata_i[31], coef_rdata_i};
        mul_b   = {tsel[31], tsel};
        state_d = crt_pkg::S_ACC;
      end
      crt_pkg::S_ACC: begin
        sum_d = sum_q + {{7{term[32]}}, term};
        j_d   = j_q + 1'b1;
        if (j_q + 1'b1 == n_q) begin
          state_d = crt_pkg::S_DONE;
        end else begin
          state_d = crt_pkg::S_CREAD;
        end
      end
      crt_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = crt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = crt_pkg::S_IDLE;
      end
    endcase
  end

  assign idle_o       = state_q == crt_pkg::S_IDLE;
  assign zone_raddr_o = ZAW'(zone_q * crt_pkg::ZONE_STRIDE + zfld);
  assign coef_raddr_o = CAW'(zone_q * MAX_COEFS + j_q);

  assign result_o.status      = status_q;
  assign result_o.temperature = (status_q == crt_pkg::STATUS_OK) ? sat_sum : '0;

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crt_pkg::S_DIV |-> rem_q < {2'b00, ad_q})
    else $error("divider remainder not below divisor");

  a_t_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crt_pkg::S_AMUL || state_q == crt_pkg::S_CREAD) |->
      (tcur_q <= crt_pkg::Q30_ONE && tcur_q >= -crt_pkg::Q30_ONE &&
       tprev_q <= crt_pkg::Q30_ONE && tprev_q >= -crt_pkg::Q30_ONE))
    else $error("Chebyshev term outside unit range");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == crt_pkg::S_IDLE) |=> state_q != crt_pkg::S_IDLE)
    else $error("convert beat did not start the sequencer");

  a_ok_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crt_pkg::S_DONE && status_q == crt_pkg::STATUS_OK) |-> zone_q < nz)
    else $error("result taken from a zone outside the searched set");
endmodule

### bench/crt_checker.sv
// Checker for the zoned Chebyshev resistance-to-temperature converter: predicts each
// reading from accepted input and configuration beats and compares result beats.
// Depends on crt_pkg and the channel interfaces in crt_ifs.sv.
module crt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  crt_in_if           in_mon,
  crt_out_if          out_mon,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int NZ = 4;
  localparam int NC = 16;
  localparam longint ONE_Q30 = 64'sd1 << 30;

  logic [31:0]        range_lo, range_hi;
  logic [2:0]         zone_limit;
  logic signed [31:0] coefs [NZ*NC];
  logic [31:0]        r_lo [NZ], r_hi [NZ];
  logic signed [31:0] lg_lo [NZ], lg_hi [NZ];
  logic [4:0]         n_coef [NZ];
  crt_pkg::crt_result_t pending_readings [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = pending_readings.size();

  function automatic longint log10_q28(logic [31:0] r);
    int        p;
    bit [63:0] m, frac, mag, prod;
    longint    l2;
    if (r == 0) return 0;
    p = 31;
    while (!r[p]) p--;
    m = 64'(r) << (31 - p);
    frac = 0;
    for (int k = 0; k < 30; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    l2 = longint'(p - 16) * ONE_Q30 + longint'(frac);
    mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
    prod = (mag * 64'd323228497 + (64'd1 << 31)) >> 32;
    return (l2 < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic logic signed [31:0] zone_temperature(int z, logic [31:0] r);
    longint num, den, an, ad, x, t_prev, t_cur, t_next, term, acc;
    num = 2 * log10_q28(r) - longint'(lg_lo[z]) - longint'(lg_hi[z]);
    den = longint'(lg_hi[z]) - longint'(lg_lo[z]);
    if (den == 0) begin
      x = 0;
    end else begin
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      x = (an >= ad) ? ONE_Q30 : (an * ONE_Q30) / ad;
      if ((num < 0) != (den < 0)) x = -x;
    end
    t_prev = ONE_Q30;
    t_cur = x;
    acc = 0;
    for (int j = 0; j < n_coef[z]; j++) begin
      if (j == 0) begin
        term = t_prev;
      end else if (j == 1) begin
        term = t_cur;
      end else begin
        t_next = unit_clamp((2 * x * t_cur) / ONE_Q30 - t_prev);
        t_prev = t_cur;
        t_cur = t_next;
        term = t_cur;
      end
      acc += (longint'(coefs[z*NC + j]) * term) / ONE_Q30;
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return 32'(acc);
  endfunction

  function automatic crt_pkg::crt_result_t predict_reading(logic [31:0] r);
    crt_pkg::crt_result_t res;
    int          nz;
    res.temperature = '0;
    if (r <= range_lo || r >= range_hi) begin
      res.status = crt_pkg::STATUS_RANGE;
      return res;
    end
    res.status = crt_pkg::STATUS_NO_ZONE;
    nz = (zone_limit > NZ) ? NZ : int'(zone_limit);
    for (int z = 0; z < nz; z++) begin
      if (r >= r_lo[z] && r <= r_hi[z]) begin
        res.temperature = zone_temperature(z, r);
        res.status = crt_pkg::STATUS_OK;
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    crt_pkg::crt_result_t got, want;
    int          zs;
    if (!rst_ni) begin
      range_lo   <= 32'h0;
      range_hi   <= 32'hFFFF_FFFF;
      zone_limit <= 3'd1;
      fails      = 0;
    end else begin
      if (cfg_we_i) begin
        case (crt_pkg::cfg_idx_e'(cfg_idx_i))
          crt_pkg::CFG_RANGE_LOW:  range_lo <= cfg_wdata_i;
          crt_pkg::CFG_RANGE_HIGH: range_hi <= cfg_wdata_i;
          crt_pkg::CFG_ZONES:      zone_limit <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        zs = int'(in_mon.zone_sel);
        case (in_mon.kind)
          crt_pkg::KIND_CONVERT:
            pending_readings.push_back(predict_reading(in_mon.resistance));
          crt_pkg::KIND_COEF:     coefs[zs*NC + int'(in_mon.coef_slot)] = in_mon.table_word;
          crt_pkg::KIND_R_LOW:    r_lo[zs] = in_mon.table_word;
          crt_pkg::KIND_R_HIGH:   r_hi[zs] = in_mon.table_word;
          crt_pkg::KIND_LOG_LOW:  lg_lo[zs] = in_mon.table_word;
          crt_pkg::KIND_LOG_HIGH: lg_hi[zs] = in_mon.table_word;
          crt_pkg::KIND_COUNT:    n_coef[zs] = (in_mon.table_word < 0) ? 5'd0 :
                                               (in_mon.table_word > NC) ? 5'(NC) :
                                               5'(in_mon.table_word);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.temperature = out_mon.temperature;
        got.status = crt_pkg::status_e'(out_mon.status);
        if (pending_readings.size() == 0) begin
          $error("unexpected result beat: temperature %0d status %0d",
                 got.temperature, got.status);
          fails++;
        end else begin
          want = pending_readings.pop_front();
          if (got.temperature !== want.temperature) begin
            $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
            fails++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
        end
      end
    end
  end

endmodule

### bench/chebyshev_resistance_to_temperature_test.sv
// Top of the converter bench: clock, reset, configuration, calibration loads and
// convert beats with random idling; the verdict comes from crt_checker.
// Depends on crt_pkg, crt_ifs.sv, crt_checker.sv and the converter RTL.
module chebyshev_resistance_to_temperature_test;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  int          fail_count, pending;
  bit          calm, hold_req;
  logic [31:0] win_lo [4], win_hi [4];

  crt_in_if  in_ch ();
  crt_out_if out_ch ();

  chebyshev_resistance_to_temperature dut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_ch), .out_o(out_ch),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  crt_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("chebyshev_resistance_to_temperature_test failed");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(logic [2:0] kind, logic [1:0] zs, logic [3:0] slot,
                           logic [31:0] word, logic [31:0] res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.zone_sel   <= zs;
    in_ch.coef_slot  <= slot;
    in_ch.table_word <= word;
    in_ch.resistance <= res;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] lo, logic [31:0] hi, logic [2:0] zones);
    cfg_we <= 1'b1; cfg_idx <= crt_pkg::CFG_RANGE_LOW; cfg_wdata <= lo; @(posedge clk);
    cfg_idx <= crt_pkg::CFG_RANGE_HIGH; cfg_wdata <= hi;           @(posedge clk);
    cfg_idx <= crt_pkg::CFG_ZONES;      cfg_wdata <= 32'(zones);   @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rough_log(logic [31:0] r);
    return 32'((longint'($clog2(r + 1)) - 16) * 80807124);
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 600 << 16)) - 32'(300 << 16);
  endfunction

  task automatic load_zone(int z, logic [31:0] lo, logic [31:0] hi, logic [31:0] count);
    logic [31:0] jit;
    win_lo[z] = lo;
    win_hi[z] = hi;
    jit = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
    send_beat(crt_pkg::KIND_R_LOW, 2'(z), 4'd0, lo, $urandom);
    send_beat(crt_pkg::KIND_R_HIGH, 2'(z), 4'd0, hi, $urandom);
    send_beat(crt_pkg::KIND_LOG_LOW, 2'(z), 4'd0, rough_log(lo) + jit, $urandom);
    send_beat(crt_pkg::KIND_LOG_HIGH, 2'(z), 4'd0, rough_log(hi) - jit, $urandom);
    send_beat(crt_pkg::KIND_COUNT, 2'(z), 4'd0, count, $urandom);
    for (int j = 0; j < 16; j++) begin
      send_beat(crt_pkg::KIND_COEF, 2'(z), 4'(j), rand_coef(), $urandom);
    end
  endtask

  task automatic random_window(int z);
    logic [31:0] lo, span;
    lo = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 16, 20000 << 16);
    span = $urandom_range(1, 3) == 1 ? $urandom_range(0, 255) : $urandom_range(1, 5000 << 16);
    load_zone(z, lo, (lo > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : lo + span,
              $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 16));
  endtask

  function automatic logic [31:0] pick_resistance();
    int z;
    z = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return win_lo[z] + 32'($urandom_range(0, win_hi[z] - win_lo[z]));
      6:                return $urandom_range(0, 1) ? win_lo[z] : win_hi[z];
      default:          return $urandom;
    endcase
  endfunction

  task automatic random_beat();
    int sel;
    logic [31:0] word;
    sel = $urandom_range(0, 19);
    if (sel < 13) begin
      send_beat(crt_pkg::KIND_CONVERT, 2'($urandom), 4'($urandom), $urandom,
                pick_resistance());
    end else if (sel < 19) begin
      word = rand_coef();
      case ($urandom_range(0, 5))
        0: send_beat(crt_pkg::KIND_COUNT, 2'($urandom), 4'($urandom),
                     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 17), $urandom);
        1: send_beat(crt_pkg::KIND_LOG_LOW, 2'($urandom), 4'($urandom), word, $urandom);
        2: send_beat(crt_pkg::KIND_LOG_HIGH, 2'($urandom), 4'($urandom), word, $urandom);
        default: send_beat(crt_pkg::KIND_COEF, 2'($urandom), 4'($urandom), word, $urandom);
      endcase
    end else begin
      send_beat(KIND_UNUSED, 2'($urandom), 4'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_idx <= crt_pkg::CFG_RANGE_LOW; cfg_wdata <= '0;
    in_ch.valid <= 1'b0; in_ch.kind <= crt_pkg::KIND_CONVERT; in_ch.zone_sel <= '0;
    in_ch.coef_slot <= '0; in_ch.table_word <= '0; in_ch.resistance <= '0;
    calm = 0;
    hold_req = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_regs(32'h0, 32'hFFFF_FFFF, 3'd4);

    load_zone(0, 32'h0001_0000, 32'h0064_0000, 32'd16);
    load_zone(1, 32'h005A_0000, 32'h03E8_0000, 32'hFFFF_FFFB);
    load_zone(2, 32'h07D0_0000, 32'h9C40_0000, 32'd99);
    load_zone(3, 32'hC000_0000, 32'hFFFF_FFFE, 32'd3);
    send_beat(crt_pkg::KIND_COEF, 2'd0, 4'd0, 32'h7FFF_FFFF, '0);
    send_beat(crt_pkg::KIND_COEF, 2'd0, 4'd1, 32'h7FFF_FFFF, '0);
    send_beat(crt_pkg::KIND_COEF, 2'd3, 4'd15, 32'h8000_0000, '0);
    send_beat(crt_pkg::KIND_LOG_HIGH, 2'd2, 4'd0, rough_log(32'h07D0_0000) + 32'h40, '0);
    send_beat(crt_pkg::KIND_LOG_LOW, 2'd2, 4'd0, rough_log(32'h07D0_0000) + 32'h40, '0);
    send_beat(KIND_UNUSED, 2'd3, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    foreach (win_lo[z]) begin
      send_beat(crt_pkg::KIND_CONVERT, 2'd0, 4'd0, '0, win_lo[z]);
      send_beat(crt_pkg::KIND_CONVERT, 2'd0, 4'd0, '0, win_hi[z]);
    end
    send_beat(crt_pkg::KIND_CONVERT, 2'd0, 4'd0, '0, 32'h0);
    send_beat(crt_pkg::KIND_CONVERT, 2'd0, 4'd0, '0, 32'hFFFF_FFFF);
    send_beat(crt_pkg::KIND_CONVERT, 2'd0, 4'd0, '0, 32'h0500_0000);
    send_beat(crt_pkg::KIND_CONVERT, 2'd0, 4'd0, '0, 32'h0000_0001);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: program_regs(32'h0000_8000, 32'hF000_0000, 3'd0);
        1: program_regs(32'hFFFF_FFFF, 32'h0, 3'd7);
        2: program_regs($urandom_range(0, 1 << 16), 32'hFFFF_FFFF - $urandom_range(0, 255),
                        3'd5);
        3: program_regs($urandom, $urandom, 3'($urandom));
        4: program_regs(32'h0, 32'hFFFF_FFFF, 3'd2);
        5: program_regs(32'h0, 32'hFFFF_FFFF, 3'd3);
        default: program_regs(32'h1, 32'hFFFF_FFFF, 3'd4);
      endcase
      if (phase == 6) calm = 1;
      for (int z = 0; z < 4; z++) if ($urandom_range(0, 1)) random_window(z);
      if (phase == 2) hold_req = 1;
      repeat (phase < 2 ? 15 : 40) random_beat();
      drain();
    end

    if (fail_count == 0) begin
      $display("chebyshev_resistance_to_temperature_test passed");
    end else begin
      $display("chebyshev_resistance_to_temperature_test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/crt_pkg.sv
hdl/crt_ifs.sv
hdl/crt_ram.sv
hdl/crt_mul.sv
hdl/crt_core.sv
hdl/chebyshev_resistance_to_temperature.sv
bench/crt_checker.sv
bench/chebyshev_resistance_to_temperature_test.sv
